// File: design/pcs_pkg.sv
// pcs_pkg: shared types, constants and helper functions of the paletted cell store.
// Used by every module of the block; depends on nothing else.
package pcs_pkg;

    localparam int CELL_W     = 12;
    localparam int TOKEN_W    = 16;
    localparam int WORD_W     = 64;
    localparam int WORD_DEPTH = 512;
    localparam int WORD_AW    = 9;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = 8;
    localparam int CNT_W      = 9;
    localparam int WIDTH_W    = 4;
    localparam int SHIFT_W    = 6;
    localparam int PER_W      = 7;
    localparam int RECIP_W    = 19;
    localparam int RECIP_SH   = 21;
    localparam int PROD_W     = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam int LINEAR_LIMIT = 16;
    localparam int MIN_WIDTH    = 4;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_GLOBAL = 2'd2
    } mode_t;

    typedef struct packed {
        logic               func;
        logic [CELL_W-1:0]  idx;
        logic [TOKEN_W-1:0] nv;
    } item_t;

    // ids per 64-bit word for a given width
    function automatic logic [PER_W-1:0] per_of(input logic [WIDTH_W-1:0] w);
        logic [PER_W-1:0] p;
        unique case (w)
            4'd1:    p = 7'd64;
            4'd2:    p = 7'd32;
            4'd3:    p = 7'd21;
            4'd4:    p = 7'd16;
            4'd5:    p = 7'd12;
            4'd6:    p = 7'd10;
            4'd7:    p = 7'd9;
            4'd8:    p = 7'd8;
            default: p = 7'd64;
        endcase
        return p;
    endfunction

    // ceil(2^21 / per_of(w)); exact floor division for 12-bit cell indexes
    function automatic logic [RECIP_W-1:0] recip_of(input logic [WIDTH_W-1:0] w);
        logic [RECIP_W-1:0] r;
        unique case (w)
            4'd1:    r = 19'd32768;
            4'd2:    r = 19'd65536;
            4'd3:    r = 19'd99865;
            4'd4:    r = 19'd131072;
            4'd5:    r = 19'd174763;
            4'd6:    r = 19'd209716;
            4'd7:    r = 19'd233017;
            4'd8:    r = 19'd262144;
            default: r = 19'd32768;
        endcase
        return r;
    endfunction

    // smallest b >= 1 with 2^b >= count
    function automatic logic [WIDTH_W-1:0] bits_for(input logic [CNT_W-1:0] count);
        logic [WIDTH_W-1:0] b;
        b = 4'd1;
        for (int k = 1; k < 9; k++) begin
            if ((10'd1 << b) < {1'b0, count}) begin
                b = b + 4'd1;
            end
        end
        return b;
    endfunction

endpackage

// File: design/pcs_front.sv
// pcs_front: input channel, cell index build and the two-entry queue to the back end.
// Depends on pcs_pkg.
module pcs_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [3:0]                   s_cell_x,
    input  logic [3:0]                   s_cell_y,
    input  logic [3:0]                   s_cell_z,
    input  logic [pcs_pkg::TOKEN_W-1:0]  s_new_value,
    output logic                         q_valid,
    input  logic                         q_ready,
    output pcs_pkg::item_t               q_item
);

    localparam int PTR_W = $clog2(pcs_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(pcs_pkg::QUEUE_DEPTH + 1);

    pcs_pkg::item_t     ent_reg [pcs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    pcs_pkg::item_t     in_item;
    logic               push;
    logic               pop;

    // index = y*256 + z*16 + x
    assign in_item.func = s_func;
    assign in_item.idx  = {s_cell_y, s_cell_z, s_cell_x};
    assign in_item.nv   = s_new_value;

    assign s_ready = (fill_reg != FILL_W'(pcs_pkg::QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = ent_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: design/pcs_addr.sv
// pcs_addr: three-stage unit that maps a cell index and id width to packed word and bit shift.
// Divides by ids-per-word through a reciprocal multiply. Depends on pcs_pkg.
module pcs_addr (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcs_pkg::CELL_W-1:0]    idx,
    input  logic [pcs_pkg::WIDTH_W-1:0]   w,
    output logic                          done,
    output logic [pcs_pkg::WORD_AW-1:0]   word,
    output logic [pcs_pkg::SHIFT_W-1:0]   shift
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic [pcs_pkg::CELL_W-1:0]    idx1_reg;
    logic [pcs_pkg::WIDTH_W-1:0]   w1_reg, w2_reg;
    logic [pcs_pkg::PROD_W-1:0]    prod1_reg;
    logic [pcs_pkg::WORD_AW-1:0]   word2_reg, word3_reg;
    logic [pcs_pkg::SHIFT_W-1:0]   rem2_reg, shift3_reg;

    logic [pcs_pkg::PROD_W-1:0]    prod1_next;
    logic [pcs_pkg::WORD_AW-1:0]   word2_next;
    logic [15:0]                   base2;
    logic [15:0]                   rem_full;
    logic [9:0]                    shift_full;

    assign prod1_next = pcs_pkg::PROD_W'(idx) * pcs_pkg::PROD_W'(pcs_pkg::recip_of(w));
    assign word2_next = prod1_reg[pcs_pkg::RECIP_SH +: pcs_pkg::WORD_AW];
    assign base2      = 16'(word2_next) * 16'(pcs_pkg::per_of(w1_reg));
    assign rem_full   = 16'(idx1_reg) - base2;
    assign shift_full = 10'(rem2_reg) * 10'(w2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            idx1_reg  <= idx;
            w1_reg    <= w;
            prod1_reg <= prod1_next;
        end
        if (v1_reg) begin
            word2_reg <= word2_next;
            rem2_reg  <= rem_full[pcs_pkg::SHIFT_W-1:0];
            w2_reg    <= w1_reg;
        end
        if (v2_reg) begin
            word3_reg  <= word2_reg;
            shift3_reg <= shift_full[pcs_pkg::SHIFT_W-1:0];
        end
    end

    assign done  = v3_reg;
    assign word  = word3_reg;
    assign shift = shift3_reg;

endmodule

// File: design/pcs_back.sv
// pcs_back: sequencer that carries out accesses: palette lookup, packed word update,
// clear on leaving single mode and repack on width growth. Depends on pcs_pkg, pcs_addr.
module pcs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  pcs_pkg::item_t                q_item,
    input  logic [pcs_pkg::TOKEN_W-1:0]   initial_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcs_pkg::TOKEN_W-1:0]   m_old_value,
    output logic [1:0]                    m_store_mode,
    output logic [pcs_pkg::WIDTH_W-1:0]   m_id_width,
    output logic [pcs_pkg::CNT_W-1:0]     m_palette_count,
    output logic                          m_write_dropped
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_PAL1, ST_ADDR, ST_AWAIT, ST_RDW, ST_PID,
        ST_SCAN, ST_SCMP, ST_NEW, ST_WRCELL,
        ST_RP_A1, ST_RP_W1, ST_RP_RD, ST_RP_W2, ST_OUT
    } state_t;

    state_t                         state_reg;
    pcs_pkg::mode_t                 mode_reg;
    logic [pcs_pkg::WIDTH_W-1:0]    width_reg;
    logic [pcs_pkg::CNT_W-1:0]      count_reg;
    pcs_pkg::item_t                 item_reg;
    logic [pcs_pkg::TOKEN_W-1:0]    old_reg;
    logic [pcs_pkg::PAL_AW-1:0]     id_reg;
    logic [pcs_pkg::CNT_W-1:0]      scan_reg;
    logic                           old_done_reg;
    logic                           dropped_reg;
    logic [pcs_pkg::WIDTH_W-1:0]    need_reg;
    logic [pcs_pkg::CELL_W-1:0]     cell_reg;
    logic [pcs_pkg::WORD_W-1:0]     acc_reg;
    logic [pcs_pkg::PAL_AW-1:0]     rp_id_reg;
    logic [pcs_pkg::WORD_AW-1:0]    clr_reg;

    logic                           m_valid_reg;
    logic [pcs_pkg::TOKEN_W-1:0]    m_old_value_reg;
    logic [1:0]                     m_store_mode_reg;
    logic [pcs_pkg::WIDTH_W-1:0]    m_id_width_reg;
    logic [pcs_pkg::CNT_W-1:0]      m_palette_count_reg;
    logic                           m_write_dropped_reg;

    logic [pcs_pkg::WORD_W-1:0]     word_mem [pcs_pkg::WORD_DEPTH];
    logic [pcs_pkg::WORD_W-1:0]     word_rd_reg;
    logic [pcs_pkg::TOKEN_W-1:0]    pal_mem [pcs_pkg::PAL_DEPTH];
    logic [pcs_pkg::TOKEN_W-1:0]    pal_rd_reg;

    logic                           mem_we;
    logic [pcs_pkg::WORD_AW-1:0]    mem_wa;
    logic [pcs_pkg::WORD_W-1:0]     mem_wd;
    logic                           pal_we;
    logic [pcs_pkg::PAL_AW-1:0]     pal_wa;
    logic [pcs_pkg::TOKEN_W-1:0]    pal_wd;
    logic [pcs_pkg::PAL_AW-1:0]     pal_ra;

    logic                           a_start;
    logic [pcs_pkg::CELL_W-1:0]     a_idx;
    logic [pcs_pkg::WIDTH_W-1:0]    a_w;
    logic                           a_done;
    logic [pcs_pkg::WORD_AW-1:0]    a_word;
    logic [pcs_pkg::SHIFT_W-1:0]    a_shift;

    logic [pcs_pkg::PAL_AW-1:0]     mask8;
    logic [pcs_pkg::WORD_W-1:0]     shifted;
    logic [pcs_pkg::PAL_AW-1:0]     cur_id;
    logic [pcs_pkg::PAL_AW-1:0]     id_eff;
    logic [pcs_pkg::WORD_W-1:0]     cell_wd;
    logic [pcs_pkg::WORD_W-1:0]     acc_new;
    logic [pcs_pkg::CNT_W-1:0]      cnt_inc;
    logic [pcs_pkg::WIDTH_W-1:0]    bits_new;
    pcs_pkg::mode_t                 mode_new;
    logic [pcs_pkg::WIDTH_W-1:0]    need_new;

    pcs_addr u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (a_start),
        .idx     (a_idx),
        .w       (a_w),
        .done    (a_done),
        .word    (a_word),
        .shift   (a_shift)
    );

    // slot extract and insert at the current width
    assign mask8   = pcs_pkg::PAL_AW'((9'd1 << width_reg) - 9'd1);
    assign shifted = word_rd_reg >> a_shift;
    assign cur_id  = shifted[pcs_pkg::PAL_AW-1:0] & mask8;
    assign id_eff  = ({1'b0, cur_id} >= count_reg) ? '0 : cur_id;
    assign cell_wd = (word_rd_reg & ~(pcs_pkg::WORD_W'(mask8) << a_shift))
                   | (pcs_pkg::WORD_W'(id_reg) << a_shift);
    assign acc_new = acc_reg | (pcs_pkg::WORD_W'(rp_id_reg) << a_shift);

    // new palette entry: mode and width it calls for
    assign cnt_inc  = count_reg + pcs_pkg::CNT_W'(1);
    assign bits_new = pcs_pkg::bits_for(cnt_inc);
    assign mode_new = (count_reg >= pcs_pkg::CNT_W'(pcs_pkg::LINEAR_LIMIT))
                    ? pcs_pkg::MODE_GLOBAL : mode_reg;
    assign need_new = (mode_new == pcs_pkg::MODE_GLOBAL) ? bits_new :
                      ((bits_new < pcs_pkg::WIDTH_W'(pcs_pkg::MIN_WIDTH))
                          ? pcs_pkg::WIDTH_W'(pcs_pkg::MIN_WIDTH) : bits_new);

    always_comb begin
        q_ready = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = a_word;
        mem_wd  = cell_wd;
        pal_we  = 1'b0;
        pal_wa  = '0;
        pal_wd  = initial_value;
        pal_ra  = scan_reg[pcs_pkg::PAL_AW-1:0];
        a_start = 1'b0;
        a_idx   = item_reg.idx;
        a_w     = width_reg;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = '0;
                pal_we = 1'b1;
            end
            ST_PAL1: begin
                pal_we = 1'b1;
                pal_wa = pcs_pkg::PAL_AW'(1);
                pal_wd = item_reg.nv;
            end
            ST_ADDR: begin
                a_start = 1'b1;
            end
            ST_RDW: begin
                pal_ra = id_eff;
            end
            ST_NEW: begin
                pal_we = (count_reg < pcs_pkg::CNT_W'(pcs_pkg::PAL_DEPTH));
                pal_wa = count_reg[pcs_pkg::PAL_AW-1:0];
                pal_wd = item_reg.nv;
            end
            ST_WRCELL: begin
                mem_we = 1'b1;
            end
            ST_RP_A1: begin
                a_start = 1'b1;
                a_idx   = cell_reg;
            end
            ST_RP_RD: begin
                a_start = 1'b1;
                a_idx   = cell_reg;
                a_w     = need_reg;
            end
            ST_RP_W2: begin
                // a group of the new packing closes at its slot 0 (cells run downward)
                mem_we = a_done && (a_shift == '0);
                mem_wd = acc_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= pcs_pkg::MODE_SINGLE;
            width_reg    <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            old_done_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg     <= q_item;
                        old_done_reg <= 1'b0;
                        dropped_reg  <= 1'b0;
                        if (mode_reg == pcs_pkg::MODE_SINGLE) begin
                            old_reg <= initial_value;
                            if (q_item.func == pcs_pkg::FUNC_WRITE &&
                                q_item.nv != initial_value) begin
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end else begin
                            state_reg <= ST_ADDR;
                        end
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + pcs_pkg::WORD_AW'(1);
                    if (clr_reg == pcs_pkg::WORD_AW'(pcs_pkg::WORD_DEPTH - 1)) begin
                        state_reg <= ST_PAL1;
                    end
                end
                ST_PAL1: begin
                    mode_reg     <= pcs_pkg::MODE_LINEAR;
                    width_reg    <= pcs_pkg::WIDTH_W'(pcs_pkg::MIN_WIDTH);
                    count_reg    <= pcs_pkg::CNT_W'(2);
                    id_reg       <= pcs_pkg::PAL_AW'(1);
                    old_done_reg <= 1'b1;
                    state_reg    <= ST_ADDR;
                end
                ST_ADDR: begin
                    state_reg <= ST_AWAIT;
                end
                ST_AWAIT: begin
                    if (a_done) begin
                        state_reg <= ST_RDW;
                    end
                end
                ST_RDW: begin
                    state_reg <= old_done_reg ? ST_WRCELL : ST_PID;
                end
                ST_PID: begin
                    old_reg <= pal_rd_reg;
                    if (item_reg.func == pcs_pkg::FUNC_WRITE) begin
                        scan_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_SCAN: begin
                    state_reg <= ST_SCMP;
                end
                ST_SCMP: begin
                    if (pal_rd_reg == item_reg.nv) begin
                        id_reg    <= scan_reg[pcs_pkg::PAL_AW-1:0];
                        state_reg <= ST_WRCELL;
                    end else if (scan_reg + pcs_pkg::CNT_W'(1) == count_reg) begin
                        state_reg <= ST_NEW;
                    end else begin
                        scan_reg  <= scan_reg + pcs_pkg::CNT_W'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_NEW: begin
                    mode_reg <= mode_new;
                    if (count_reg >= pcs_pkg::CNT_W'(pcs_pkg::PAL_DEPTH)) begin
                        dropped_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else begin
                        id_reg       <= count_reg[pcs_pkg::PAL_AW-1:0];
                        count_reg    <= cnt_inc;
                        old_done_reg <= 1'b1;
                        if (need_new > width_reg) begin
                            need_reg  <= need_new;
                            cell_reg  <= pcs_pkg::CELL_W'(4095);
                            acc_reg   <= '0;
                            state_reg <= ST_RP_A1;
                        end else begin
                            state_reg <= ST_WRCELL;
                        end
                    end
                end
                ST_WRCELL: begin
                    state_reg <= ST_OUT;
                end
                ST_RP_A1: begin
                    state_reg <= ST_RP_W1;
                end
                ST_RP_W1: begin
                    if (a_done) begin
                        state_reg <= ST_RP_RD;
                    end
                end
                ST_RP_RD: begin
                    rp_id_reg <= cur_id;
                    state_reg <= ST_RP_W2;
                end
                ST_RP_W2: begin
                    if (a_done) begin
                        acc_reg <= (a_shift == '0) ? '0 : acc_new;
                        if (cell_reg == '0) begin
                            width_reg <= need_reg;
                            state_reg <= ST_ADDR;
                        end else begin
                            cell_reg  <= cell_reg - pcs_pkg::CELL_W'(1);
                            state_reg <= ST_RP_A1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_old_value_reg     <= old_reg;
                        m_store_mode_reg    <= mode_reg;
                        m_id_width_reg      <= (mode_reg == pcs_pkg::MODE_SINGLE)
                                               ? '0 : width_reg;
                        m_palette_count_reg <= (mode_reg == pcs_pkg::MODE_SINGLE)
                                               ? pcs_pkg::CNT_W'(1) : count_reg;
                        m_write_dropped_reg <= dropped_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[mem_wa] <= mem_wd;
        end
        word_rd_reg <= word_mem[a_word];
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= pal_wd;
        end
        pal_rd_reg <= pal_mem[pal_ra];
    end

    assign m_valid         = m_valid_reg;
    assign m_old_value     = m_old_value_reg;
    assign m_store_mode    = m_store_mode_reg;
    assign m_id_width      = m_id_width_reg;
    assign m_palette_count = m_palette_count_reg;
    assign m_write_dropped = m_write_dropped_reg;

endmodule

// File: design/palette_packed_cell_store.sv
// palette_packed_cell_store: top level; config register port, front queue and back sequencer.
// Depends on pcs_pkg, pcs_front, pcs_back.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid / s_ready | func, cell_x/y/z, new_value
//   m_      | out       | m_valid / m_ready | old_value, store_mode, id_width,
//           |           |                   | palette_count, write_dropped
//   apb     | in        | psel/penable      | initial_value at byte address 0
//
// Outside single mode a read goes through the three-stage address divide and the registered
// word and palette reads. A write also scans the palette entries one after another.
// Leaving single mode clears the 512 packed words, one a cycle; a width growth repacks
// all 4096 cells through the shared address unit.
// Reset is synchronous; the stores need none. Two items queue while the back end works,
// and a finished result waits in the output register without holding up the front.
module palette_packed_cell_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [3:0]                    s_cell_x,
    input  logic [3:0]                    s_cell_y,
    input  logic [3:0]                    s_cell_z,
    input  logic [pcs_pkg::TOKEN_W-1:0]   s_new_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcs_pkg::TOKEN_W-1:0]   m_old_value,
    output logic [1:0]                    m_store_mode,
    output logic [pcs_pkg::WIDTH_W-1:0]   m_id_width,
    output logic [pcs_pkg::CNT_W-1:0]     m_palette_count,
    output logic                          m_write_dropped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic REG_INIT = 1'b0;

    logic [pcs_pkg::TOKEN_W-1:0] init_reg;
    logic                        q_valid;
    logic                        q_ready;
    pcs_pkg::item_t              q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INIT) ? 32'(init_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_INIT) begin
            init_reg <= pwdata[pcs_pkg::TOKEN_W-1:0];
        end
    end

    pcs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .s_cell_z    (s_cell_z),
        .s_new_value (s_new_value),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    pcs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .initial_value   (init_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_old_value     (m_old_value),
        .m_store_mode    (m_store_mode),
        .m_id_width      (m_id_width),
        .m_palette_count (m_palette_count),
        .m_write_dropped (m_write_dropped)
    );

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for palette_packed_cell_store.
// Drives cell reads and writes, predicts each result with a palette/packed-word model.
// Depends on pcs_pkg and the design sources.
`timescale 1ns / 1ps

class cell_store_scoreboard;
    logic [15:0] init_token;
    pcs_pkg::mode_t mode;
    logic [15:0] palette[256];
    int unsigned pal_used;
    int unsigned id_bits;
    logic [7:0] cell_id[4096];
    logic [15:0] exp_old[$];
    logic [1:0] exp_mode[$];
    logic [3:0] exp_width[$];
    logic [8:0] exp_count[$];
    logic exp_drop[$];
    int errors;

    function new();
        init_token = 0;
        mode = pcs_pkg::MODE_SINGLE;
        pal_used = 0;
        id_bits = 0;
        errors = 0;
    endfunction

    function int unsigned width_for(int unsigned cnt);
        int unsigned b;
        b = 1;
        while (b < 16 && (1 << b) < cnt) b++;
        return b;
    endfunction

    // ids are kept unpacked; repacking preserves ids (all fit in the grown width)
    function void note_access(logic func, logic [11:0] idx, logic [15:0] nv);
        logic [15:0] old;
        int unsigned id, b, i;
        bit found, dropped;
        found = 0;
        dropped = 0;
        id = 0;
        if (mode == pcs_pkg::MODE_SINGLE) begin
            old = init_token;
        end else begin
            id = cell_id[idx];
            if (id >= pal_used) id = 0;
            old = palette[id];
        end
        if (func == pcs_pkg::FUNC_WRITE) begin
            if (mode == pcs_pkg::MODE_SINGLE) begin
                if (nv != init_token) begin
                    mode = pcs_pkg::MODE_LINEAR;
                    palette[0] = init_token;
                    palette[1] = nv;
                    pal_used = 2;
                    id_bits = pcs_pkg::MIN_WIDTH;
                    foreach (cell_id[k]) cell_id[k] = 0;
                    cell_id[idx] = 1;
                end
            end else begin
                id = 0;
                for (i = 0; i < pal_used; i++) begin
                    if (!found && palette[i] == nv) begin
                        id = i;
                        found = 1;
                    end
                end
                if (!found) begin
                    if (pal_used >= pcs_pkg::LINEAR_LIMIT) mode = pcs_pkg::MODE_GLOBAL;
                    if (pal_used >= 256) begin
                        dropped = 1;
                    end else begin
                        id = pal_used;
                        palette[id] = nv;
                        pal_used++;
                        b = width_for(pal_used);
                        if (mode != pcs_pkg::MODE_GLOBAL && b < pcs_pkg::MIN_WIDTH)
                            b = pcs_pkg::MIN_WIDTH;
                        if (b > id_bits) id_bits = b;
                    end
                end
                if (!dropped) cell_id[idx] = id;
            end
        end
        exp_old.push_back(old);
        exp_mode.push_back(mode);
        exp_width.push_back(mode == pcs_pkg::MODE_SINGLE ? 4'd0 : id_bits[3:0]);
        exp_count.push_back(mode == pcs_pkg::MODE_SINGLE ? 9'd1 : pal_used[8:0]);
        exp_drop.push_back(dropped);
    endfunction

    function void check_result(logic [15:0] old, logic [1:0] md, logic [3:0] w,
                               logic [8:0] cnt, logic drop);
        if (exp_old.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: old=%0h", old);
            return;
        end
        if (old !== exp_old[0] || md !== exp_mode[0] || w !== exp_width[0] ||
            cnt !== exp_count[0] || drop !== exp_drop[0]) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: exp old=%0h mode=%0d w=%0d cnt=%0d drop=%0d,",
                          " got %0h %0d %0d %0d %0d"},
                         exp_old[0], exp_mode[0], exp_width[0], exp_count[0], exp_drop[0],
                         old, md, w, cnt, drop);
        end
        void'(exp_old.pop_front());
        void'(exp_mode.pop_front());
        void'(exp_width.pop_front());
        void'(exp_count.pop_front());
        void'(exp_drop.pop_front());
    endfunction

    function int pending();
        return exp_old.size();
    endfunction
endclass

module tb_top;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    logic s_func = 0;
    logic [3:0] s_cell_x = 0, s_cell_y = 0, s_cell_z = 0;
    logic [15:0] s_new_value = 0;
    logic m_valid, m_ready = 0;
    logic [15:0] m_old_value;
    logic [1:0] m_store_mode;
    logic [3:0] m_id_width;
    logic [8:0] m_palette_count;
    logic m_write_dropped;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;

    localparam int ADDR_INITIAL_VALUE = 0;

    cell_store_scoreboard sb = new();
    int cycles = 0;
    bit quiet_sink = 0;
    bit quiet_source = 0;

    palette_packed_cell_store u_top (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result sink with random stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_old_value, m_store_mode, m_id_width, m_palette_count,
                            m_write_dropped);
        m_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 14);
    end

    task automatic apb_write(input int addr, input logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr[2:0]; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_INITIAL_VALUE && sb.mode == pcs_pkg::MODE_SINGLE)
            sb.init_token = data[15:0];
        else if (addr == ADDR_INITIAL_VALUE)
            sb.init_token = data[15:0];
    endtask

    // valid stays high between back-to-back beats; it drops for random gaps and in drain
    task automatic send_access(input logic func, input logic [11:0] idx,
                               input logic [15:0] nv);
        while (!quiet_source && $urandom_range(99) < 14) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_func <= func;
        s_cell_x <= idx[3:0]; s_cell_z <= idx[7:4]; s_cell_y <= idx[11:8];
        s_new_value <= nv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_access(func, idx, nv);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // one phase: random reads and writes, most writes drawing tokens from a pool sized to reach a given palette size
    task automatic run_phase(input int items, input int pool, input int token_base);
        logic [11:0] idx;
        for (int i = 0; i < items; i++) begin
            idx = 12'($urandom_range(4095));
            if ($urandom_range(99) < 10)
                idx = {1'($urandom_range(1)), 7'h0, 4'($urandom_range(15))};
            if ($urandom_range(99) < 40)
                send_access(pcs_pkg::FUNC_READ, idx, 16'($urandom));
            else if ($urandom_range(99) < 5)
                send_access(pcs_pkg::FUNC_WRITE, idx, 16'($urandom));
            else
                send_access(pcs_pkg::FUNC_WRITE, idx,
                            16'(token_base + $urandom_range(pool - 1)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: single mode reads, same-token write, corners, then leave single
        apb_write(ADDR_INITIAL_VALUE, 32'h0000_ffff);
        send_access(pcs_pkg::FUNC_READ, 12'h000, 16'h0);
        send_access(pcs_pkg::FUNC_READ, 12'hfff, 16'hffff);
        send_access(pcs_pkg::FUNC_WRITE, 12'h123, 16'hffff);
        drain();
        apb_write(ADDR_INITIAL_VALUE, 32'h0000_0000);
        send_access(pcs_pkg::FUNC_READ, 12'h0f0, 16'h0);
        send_access(pcs_pkg::FUNC_WRITE, 12'hfff, 16'hffff);
        send_access(pcs_pkg::FUNC_READ, 12'hfff, 16'h0);
        send_access(pcs_pkg::FUNC_READ, 12'h000, 16'h0);
        send_access(pcs_pkg::FUNC_WRITE, 12'h000, 16'h0000);
        send_access(pcs_pkg::FUNC_WRITE, 12'hfff, 16'h0000);
        for (int t = 2; t < 18; t++)
            send_access(pcs_pkg::FUNC_WRITE, 12'(t * 37), 16'(t * 1111));
        drain();
        apb_write(ADDR_INITIAL_VALUE, 32'h0000_5a5a);   // ignored outside single mode
        run_phase(200, 40, 0);
        quiet_source = 1; quiet_sink = 1;
        run_phase(150, 64, 2000);
        quiet_source = 0; quiet_sink = 0;
        run_phase(350, 300, 4000);    // fills the palette, then drops
        run_phase(400, 500, 0);
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
